[rtl/core/rjdm_pkg.sv]
`default_nettype none

package rjdm_pkg;

   // default sizes
   localparam int DEPTH_DEF       = 16384;
   localparam int SAMPLE_BITS_DEF = 24;

   // register field widths
   localparam int CFG_BITS       = 14;
   localparam int MIX_BITS       = 17;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;

   // random generator
   localparam logic [31:0] LCG_MUL  = 32'd1664525;
   localparam logic [31:0] LCG_ADD  = 32'd1013904223;
   localparam logic [31:0] LCG_SEED = 32'h12345678;

   // unity gain in Q16
   localparam logic [MIX_BITS-1:0] UNITY = 17'd65536;

   // divisor of the jitter scaling
   localparam logic [16:0] JIT_DIV = 17'd65535;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ACTIVE,
      REG_BASE_DELAY,
      REG_JITTER_RANGE,
      REG_MIX
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LCG_MUL,
      ST_LCG_ADD,
      ST_OFS_MUL,
      ST_DIV,
      ST_ADDR,
      ST_READ,
      ST_MIX_MUL,
      ST_MIX_SUM,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic lcg_mul;
      logic lcg_add;
      logic ofs_mul;
      logic div;
      logic addr;
      logic read;
      logic mix_mul;
      logic mix_sum;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic active;
      logic deactivate;
      logic clear_last;
   } ctrl_status_type;

   // delay setting limited to 1..limit
   function automatic logic [CFG_BITS-1:0] clamp_delay(input logic [CFG_BITS-1:0] v,
                                                       input logic [31:0] limit);
      logic [CFG_BITS-1:0] r;
      if (v == '0) begin
         r = CFG_BITS'(1);
      end else if (32'(v) > limit) begin
         r = CFG_BITS'(limit);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/rjdm_ctrl.sv]
`default_nettype none

module rjdm_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rjdm_pkg::ctrl_status_type status,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rjdm_pkg::ctrl_cmd_type        cmd
);

   rjdm_pkg::ctrl_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      if (status.deactivate) begin
         state_in = rjdm_pkg::ST_CLEAR;
      end else begin
         unique case (state_ff)
            rjdm_pkg::ST_CLEAR: begin
               if (status.clear_last) state_in = rjdm_pkg::ST_IDLE;
            end
            rjdm_pkg::ST_IDLE: begin
               if (req_valid) begin
                  state_in = status.active ? rjdm_pkg::ST_LCG_MUL : rjdm_pkg::ST_FINISH;
               end
            end
            rjdm_pkg::ST_LCG_MUL: state_in = rjdm_pkg::ST_LCG_ADD;
            rjdm_pkg::ST_LCG_ADD: state_in = rjdm_pkg::ST_OFS_MUL;
            rjdm_pkg::ST_OFS_MUL: state_in = rjdm_pkg::ST_DIV;
            rjdm_pkg::ST_DIV:     state_in = rjdm_pkg::ST_ADDR;
            rjdm_pkg::ST_ADDR:    state_in = rjdm_pkg::ST_READ;
            rjdm_pkg::ST_READ:    state_in = rjdm_pkg::ST_MIX_MUL;
            rjdm_pkg::ST_MIX_MUL: state_in = rjdm_pkg::ST_MIX_SUM;
            rjdm_pkg::ST_MIX_SUM: state_in = rjdm_pkg::ST_FINISH;
            rjdm_pkg::ST_FINISH: begin
               if (out_free) state_in = rjdm_pkg::ST_IDLE;
            end
            default: state_in = rjdm_pkg::ST_CLEAR;
         endcase
      end
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rjdm_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         rjdm_pkg::ST_IDLE: begin
            req_ready  = !status.deactivate;
            cmd.accept = req_valid && !status.deactivate;
         end
         rjdm_pkg::ST_LCG_MUL: cmd.lcg_mul  = 1'b1;
         rjdm_pkg::ST_LCG_ADD: cmd.lcg_add  = 1'b1;
         rjdm_pkg::ST_OFS_MUL: cmd.ofs_mul  = 1'b1;
         rjdm_pkg::ST_DIV:     cmd.div      = 1'b1;
         rjdm_pkg::ST_ADDR:    cmd.addr     = 1'b1;
         rjdm_pkg::ST_READ:    cmd.read     = 1'b1;
         rjdm_pkg::ST_MIX_MUL: cmd.mix_mul  = 1'b1;
         rjdm_pkg::ST_MIX_SUM: cmd.mix_sum  = 1'b1;
         rjdm_pkg::ST_FINISH:  cmd.load_out = out_free;
         default: cmd = '0;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rjdm_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rjdm_datapath.sv]
`default_nettype none

module rjdm_datapath #(
   parameter int DEPTH       = rjdm_pkg::DEPTH_DEF,
   parameter int SAMPLE_BITS = rjdm_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire rjdm_pkg::ctrl_cmd_type                cmd,
   output rjdm_pkg::ctrl_status_type                  status,
   input  wire logic                                  csr_we,
   input  wire logic [rjdm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [rjdm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_left_in,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_right_in,
   output logic signed [SAMPLE_BITS-1:0]              rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]              rsp_right_out
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CB = rjdm_pkg::CFG_BITS;
   localparam int MB = rjdm_pkg::MIX_BITS;
   localparam int XW = ((AW > CB) ? AW : CB) + 3;
   localparam int PW = SAMPLE_BITS + MB + 1;
   localparam int SW = PW + 1;
   localparam logic [AW-1:0]        LAST_IDX  = AW'(DEPTH - 1);
   localparam logic [31:0]          DELAY_MAX = 32'(DEPTH - 2);
   localparam logic signed [XW-1:0] DEPTH_X   = XW'(DEPTH);

   // configuration registers
   logic          active_ff, active_in;
   logic [CB-1:0] base_ff, base_in;
   logic [CB-1:0] jit_ff, jit_in;
   logic [MB-1:0] mix_ff, mix_in;
   logic          deactivate;

   // state
   logic [31:0]   lcg_ff, lcg_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] clr_ptr_ff, clr_ptr_in;

   // item registers
   logic signed [SAMPLE_BITS-1:0] in_l_ff, in_r_ff;
   logic                          pass_ff;
   logic [31:0]                   lcg_prod_ff;
   logic [29:0]                   mag_prod_ff;
   logic                          neg_ff;
   logic signed [XW-1:0]          diff_ff;
   logic [CB-1:0]                 q_ff;
   logic [AW-1:0]                 addr_ff;
   logic [2*SAMPLE_BITS-1:0]      rd_ff;
   logic signed [PW-1:0]          dry_l_ff, dry_r_ff, wet_l_ff, wet_r_ff;
   logic signed [SW-1:0]          acc_l_ff, acc_r_ff;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_r_ff;

   // combinational values
   logic [CB-1:0]        base_c, jit_c;
   logic [MB-1:0]        wet_w, dry_w;
   logic [15:0]          rnd, mag;
   logic [29:0]          mag_prod_in;
   logic signed [XW-1:0] diff_in;
   logic [CB-1:0]        q0;
   logic [16:0]          rem;
   logic [CB-1:0]        q_in;
   logic signed [XW-1:0] t_addr, m_addr;
   logic signed [PW-1:0] dry_l_in, dry_r_in, wet_l_in, wet_r_in;
   logic signed [SW-1:0] acc_l_in, acc_r_in;

   // delay store
   logic [2*SAMPLE_BITS-1:0] store_mem [DEPTH];
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [2*SAMPLE_BITS-1:0] mem_wdata;

   // register writes
   assign deactivate = csr_we && (rjdm_pkg::csr_index_type'(csr_index) == rjdm_pkg::REG_ACTIVE)
                       && !csr_wdata[0] && active_ff;

   always_comb begin
      active_in = active_ff;
      base_in   = base_ff;
      jit_in    = jit_ff;
      mix_in    = mix_ff;
      if (csr_we) begin
         unique case (rjdm_pkg::csr_index_type'(csr_index))
            rjdm_pkg::REG_ACTIVE:       active_in = csr_wdata[0];
            rjdm_pkg::REG_BASE_DELAY:   base_in   = csr_wdata[CB-1:0];
            rjdm_pkg::REG_JITTER_RANGE: jit_in    = csr_wdata[CB-1:0];
            rjdm_pkg::REG_MIX:          mix_in    = csr_wdata[MB-1:0];
            default: active_in = active_ff;
         endcase
      end
   end

   // generator, write pointer and clearing sweep
   always_comb begin
      lcg_in     = lcg_ff;
      wp_in      = wp_ff;
      clr_ptr_in = clr_ptr_ff;
      if (deactivate) begin
         lcg_in     = rjdm_pkg::LCG_SEED;
         wp_in      = '0;
         clr_ptr_in = '0;
      end else begin
         if (cmd.lcg_add) lcg_in = lcg_prod_ff + rjdm_pkg::LCG_ADD;
         if (cmd.mix_mul) wp_in = (wp_ff == LAST_IDX) ? '0 : wp_ff + AW'(1);
         if (cmd.clear_step) clr_ptr_in = (clr_ptr_ff == LAST_IDX) ? '0 : clr_ptr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         base_ff    <= CB'(1);
         jit_ff     <= CB'(1);
         mix_ff     <= '0;
         lcg_ff     <= rjdm_pkg::LCG_SEED;
         wp_ff      <= '0;
         clr_ptr_ff <= '0;
      end else begin
         active_ff  <= active_in;
         base_ff    <= base_in;
         jit_ff     <= jit_in;
         mix_ff     <= mix_in;
         lcg_ff     <= lcg_in;
         wp_ff      <= wp_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   assign status.active     = active_ff;
   assign status.deactivate = deactivate;
   assign status.clear_last = (clr_ptr_ff == LAST_IDX);

   // effective settings
   assign base_c = rjdm_pkg::clamp_delay(base_ff, DELAY_MAX);
   assign jit_c  = rjdm_pkg::clamp_delay(jit_ff, DELAY_MAX);
   assign wet_w  = (mix_ff > rjdm_pkg::UNITY) ? rjdm_pkg::UNITY : mix_ff;
   assign dry_w  = rjdm_pkg::UNITY - wet_w;

   // magnitude and sign of 2r - 65535 (always odd, never zero)
   assign rnd = lcg_ff[23:8];
   assign mag = rnd[15] ? {rnd[14:0], 1'b1} : ~{rnd[14:0], 1'b0};
   assign mag_prod_in = 30'(mag) * 30'(jit_c);
   assign diff_in = $signed(XW'(wp_ff)) - $signed(XW'(base_c));

   // divide by 65535: quotient from the top bits, one correction step
   assign q0   = mag_prod_ff[29:16];
   assign rem  = 17'(mag_prod_ff[15:0]) + 17'(q0);
   assign q_in = q0 + ((rem >= rjdm_pkg::JIT_DIV) ? CB'(1) : CB'(0));

   // read address, wrapped into 0..DEPTH-1
   assign t_addr = neg_ff ? (diff_ff + $signed(XW'(q_ff))) : (diff_ff - $signed(XW'(q_ff)));

   always_comb begin
      if (t_addr < 0) begin
         if ((t_addr + DEPTH_X) < 0) begin
            m_addr = t_addr + DEPTH_X + DEPTH_X;
         end else begin
            m_addr = t_addr + DEPTH_X;
         end
      end else if (t_addr >= DEPTH_X) begin
         m_addr = t_addr - DEPTH_X;
      end else begin
         m_addr = t_addr;
      end
   end

   // wet and dry products
   assign dry_l_in = PW'(in_l_ff) * PW'($signed({1'b0, dry_w}));
   assign dry_r_in = PW'(in_r_ff) * PW'($signed({1'b0, dry_w}));
   assign wet_l_in = PW'($signed(rd_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]))
                     * PW'($signed({1'b0, wet_w}));
   assign wet_r_in = PW'($signed(rd_ff[SAMPLE_BITS-1:0])) * PW'($signed({1'b0, wet_w}));
   assign acc_l_in = SW'(dry_l_ff) + SW'(wet_l_ff);
   assign acc_r_in = SW'(dry_r_ff) + SW'(wet_r_ff);

   // item pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         in_l_ff <= req_left_in;
         in_r_ff <= req_right_in;
         pass_ff <= !active_ff;
      end
      if (cmd.lcg_mul) lcg_prod_ff <= lcg_ff * rjdm_pkg::LCG_MUL;
      if (cmd.ofs_mul) begin
         mag_prod_ff <= mag_prod_in;
         neg_ff      <= !rnd[15];
         diff_ff     <= diff_in;
      end
      if (cmd.div) q_ff <= q_in;
      if (cmd.addr) addr_ff <= m_addr[AW-1:0];
      if (cmd.mix_mul) begin
         dry_l_ff <= dry_l_in;
         dry_r_ff <= dry_r_in;
         wet_l_ff <= wet_l_in;
         wet_r_ff <= wet_r_in;
      end
      if (cmd.mix_sum) begin
         acc_l_ff <= acc_l_in;
         acc_r_ff <= acc_r_in;
      end
      if (cmd.load_out) begin
         out_l_ff <= pass_ff ? in_l_ff : acc_l_ff[SAMPLE_BITS+15:16];
         out_r_ff <= pass_ff ? in_r_ff : acc_r_ff[SAMPLE_BITS+15:16];
      end
   end

   // store port: clearing sweep or dry frame write, read in the cycle before the write
   assign mem_we    = cmd.clear_step || cmd.mix_mul;
   assign mem_waddr = cmd.clear_step ? clr_ptr_ff : wp_ff;
   assign mem_wdata = cmd.clear_step ? '0 : {in_l_ff, in_r_ff};

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
      if (cmd.read) rd_ff <= store_mem[addr_ff];
   end

   assign rsp_left_out  = out_l_ff;
   assign rsp_right_out = out_r_ff;

endmodule

`default_nettype wire

[rtl/core/random_jitter_delay_mix_top.sv]
// active frame: after acceptance the single sequencer steps through the LCG, offset, divide, address,
// read and mix states to FINISH; bypassed frames (effect off) go from acceptance straight to FINISH;
// the result is loaded in FINISH once the output is free, and the next frame is taken back in IDLE
// reset, and a write that turns the effect off, start a clearing sweep over all DEPTH store entries
// (16384 by default) during which no frame is taken; register writes are taken throughout
`default_nettype none

module random_jitter_delay_mix_top #(
   parameter int DEPTH       = rjdm_pkg::DEPTH_DEF,
   parameter int SAMPLE_BITS = rjdm_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_left_in,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_right_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]            rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]            rsp_right_out,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rjdm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rjdm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   rjdm_pkg::ctrl_cmd_type    cmd;
   rjdm_pkg::ctrl_status_type status;
   logic                      csr_we;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   rjdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   rjdm_datapath #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

endmodule

`default_nettype wire

[rtl/core/rjdm_checker.sv]
`default_nettype none

module rjdm_checker #(
   parameter int SAMPLE_BITS = rjdm_pkg::SAMPLE_BITS_DEF
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic signed [SAMPLE_BITS-1:0]       req_left_in,
   input wire logic signed [SAMPLE_BITS-1:0]       req_right_in,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [SAMPLE_BITS-1:0]       rsp_left_out,
   input wire logic signed [SAMPLE_BITS-1:0]       rsp_right_out,
   input wire logic                                csr_valid,
   input wire logic                                csr_ready,
   input wire logic [rjdm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input wire logic [rjdm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // the store is swept clean after reset, so no frame is taken straight away
   a_no_take_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("frame taken during clearing sweep after reset");

   // one frame at a time: the sequencer leaves idle once a transaction is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction taken while a frame is in progress");

   // a waiting result stays offered
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // a waiting result keeps its samples
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_left_out) && $stable(rsp_right_out)))
      else $error("result samples changed while waiting");

endmodule

bind random_jitter_delay_mix_top rjdm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_rjdm_checker (.*);

`default_nettype wire

[verif/tb_random_jitter_delay_mix_top.sv]
`default_nettype none

module tb_random_jitter_delay_mix_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH    = rjdm_pkg::DEPTH_DEF;
   localparam int SAMPLE_W      = rjdm_pkg::SAMPLE_BITS_DEF;
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int FULL_WET      = 65536;
   localparam int IDLE_PERCENT  = 37;
   localparam int RANDOM_FRAMES = 630;
   localparam int CALM_FRAMES   = 80;
   localparam int TAIL_CYCLES   = 30;
   localparam int CYCLE_LIMIT   = 1000000;

   localparam logic [31:0] RNG_MULT = 32'd1664525;
   localparam logic [31:0] RNG_INCR = 32'd1013904223;
   localparam logic [31:0] RNG_SEED = 32'h12345678;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef struct packed {
      sample_type left;
      sample_type right;
   } stereo_frame_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   sample_type                          req_left_in;
   sample_type                          req_right_in;
   logic                                rsp_valid;
   logic                                rsp_ready;
   sample_type                          rsp_left_out;
   sample_type                          rsp_right_out;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [rjdm_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [rjdm_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   // delay line model: store, write position, generator, registers
   sample_type  line_left [RING_DEPTH];
   sample_type  line_right [RING_DEPTH];
   int          line_wptr;
   logic [31:0] jitter_rng;
   logic        cfg_active;
   logic [13:0] cfg_base;
   logic [13:0] cfg_jitter;
   logic [16:0] cfg_mix;

   stereo_frame_type pending_frames[$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   bit               calm_mode      = 1'b0;

   random_jitter_delay_mix_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit reached with %0d frames outstanding", $time,
                  pending_frames.size());
         $display("tb_random_jitter_delay_mix_top: FAIL");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= calm_mode || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      stereo_frame_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h %h", $time,
                     rsp_left_out, rsp_right_out);
            mismatch_count++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_left_out !== want.left) begin
               $display("%0t: left_out mismatch, expected %h actual %h", $time,
                        want.left, rsp_left_out);
               mismatch_count++;
            end
            if (rsp_right_out !== want.right) begin
               $display("%0t: right_out mismatch, expected %h actual %h", $time,
                        want.right, rsp_right_out);
               mismatch_count++;
            end
         end
      end
   end

   // empty store, rewound pointer, reseeded generator
   function automatic void clear_delay_line();
      for (int i = 0; i < RING_DEPTH; i++) begin
         line_left[i]  = '0;
         line_right[i] = '0;
      end
      line_wptr  = 0;
      jitter_rng = RNG_SEED;
   endfunction

   // delay settings are used within 1..depth-2
   function automatic longint limit_taps(input logic [13:0] v);
      longint lim;
      lim = RING_DEPTH - 2;
      if (v == '0) begin
         return 1;
      end
      if (longint'(v) > lim) begin
         return lim;
      end
      return longint'(v);
   endfunction

   // floor of the q16 weighted sum of dry and delayed samples
   function automatic sample_type blend_sample(input longint dry, input longint wet,
                                               input longint wet_gain);
      longint acc;
      acc = dry * (FULL_WET - wet_gain) + wet * wet_gain;
      return sample_type'(acc >>> 16);
   endfunction

   // one frame through the jittered delay line
   function automatic stereo_frame_type predict_frame(input sample_type l_in,
                                                      input sample_type r_in);
      stereo_frame_type res;
      longint           base, span, wet_gain, r, offset, addr, wp;
      sample_type       l_del, r_del;
      if (!cfg_active) begin
         res.left  = l_in;
         res.right = r_in;
         return res;
      end
      base     = limit_taps(cfg_base);
      span     = limit_taps(cfg_jitter);
      wet_gain = (cfg_mix > FULL_WET) ? FULL_WET : cfg_mix;
      // advance the generator and scale its middle bits to -span..span
      jitter_rng = jitter_rng * RNG_MULT + RNG_INCR;
      r          = jitter_rng[23:8];
      offset     = ((2 * r - 65535) * span) / 65535;
      wp         = line_wptr;
      addr       = (wp - base - offset) % RING_DEPTH;
      if (addr < 0) begin
         addr += RING_DEPTH;
      end
      // old contents come back before the dry frame goes in
      l_del                 = line_left[addr];
      r_del                 = line_right[addr];
      line_left[line_wptr]  = l_in;
      line_right[line_wptr] = r_in;
      line_wptr             = (line_wptr + 1) % RING_DEPTH;
      res.left              = blend_sample(l_in, l_del, wet_gain);
      res.right             = blend_sample(r_in, r_del, wet_gain);
      return res;
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return '1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // one register write transaction, model updated when it is taken
   task automatic write_reg(input rjdm_pkg::csr_index_type idx, input logic [16:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rjdm_pkg::REG_ACTIVE: begin
            if (data[0] != cfg_active) begin
               cfg_active = data[0];
               if (!data[0]) begin
                  clear_delay_line();
               end
            end
         end
         rjdm_pkg::REG_BASE_DELAY:   cfg_base   = data[13:0];
         rjdm_pkg::REG_JITTER_RANGE: cfg_jitter = data[13:0];
         rjdm_pkg::REG_MIX:          cfg_mix    = data[16:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one frame transaction with random gaps in front of it
   task automatic send_frame(input sample_type l_in, input sample_type r_in);
      while (!calm_mode && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_left_in  <= l_in;
      req_right_in <= r_in;
      do @(posedge clock); while (!req_ready);
      pending_frames.push_back(predict_frame(l_in, r_in));
   endtask

   // hold the sender until every predicted result is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // effect off: frames pass through whatever the other registers say
   task automatic test_bypass();
      wait_idle();
      write_reg(rjdm_pkg::REG_ACTIVE, 17'd0);
      write_reg(rjdm_pkg::REG_MIX, 17'(FULL_WET));
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
      send_frame('0, '1);
      send_frame('1, '0);
   endtask

   // effect on: full scale steps, mix corners and clamped delay settings
   task automatic test_wet_path();
      wait_idle();
      write_reg(rjdm_pkg::REG_BASE_DELAY, 17'd1);
      write_reg(rjdm_pkg::REG_JITTER_RANGE, 17'd1);
      write_reg(rjdm_pkg::REG_MIX, 17'(FULL_WET));
      write_reg(rjdm_pkg::REG_ACTIVE, 17'd1);
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
      send_frame('0, '1);
      send_frame(SAMPLE_MAX, SAMPLE_MAX);
      send_frame(SAMPLE_MIN, SAMPLE_MIN);
      send_frame('1, '0);
      // active rewritten unchanged, dry only
      wait_idle();
      write_reg(rjdm_pkg::REG_ACTIVE, 17'd1);
      write_reg(rjdm_pkg::REG_MIX, 17'd0);
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(SAMPLE_MIN, '1);
      // wet gain above unity
      wait_idle();
      write_reg(rjdm_pkg::REG_MIX, 17'h1FFFF);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
      send_frame('1, SAMPLE_MIN);
      // zero delay settings used as one
      wait_idle();
      write_reg(rjdm_pkg::REG_BASE_DELAY, 17'd0);
      write_reg(rjdm_pkg::REG_JITTER_RANGE, 17'd0);
      write_reg(rjdm_pkg::REG_MIX, 17'd32768);
      send_frame(SAMPLE_MAX, '0);
      send_frame('0, SAMPLE_MIN);
      // oversized delay settings, upper data bits set
      wait_idle();
      write_reg(rjdm_pkg::REG_BASE_DELAY, 17'h1FFFF);
      write_reg(rjdm_pkg::REG_JITTER_RANGE, 17'h3FFF);
      write_reg(rjdm_pkg::REG_MIX, 17'd49152);
      send_frame(SAMPLE_MAX, SAMPLE_MAX);
      send_frame(SAMPLE_MIN, '1);
   endtask

   // turning the effect off wipes the line, back on starts from silence
   task automatic test_deactivate();
      wait_idle();
      write_reg(rjdm_pkg::REG_ACTIVE, 17'd0);
      send_frame(24'h123456, 24'hEDCBAA);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
      wait_idle();
      write_reg(rjdm_pkg::REG_BASE_DELAY, 17'd2);
      write_reg(rjdm_pkg::REG_JITTER_RANGE, 17'd1);
      write_reg(rjdm_pkg::REG_MIX, 17'(FULL_WET));
      write_reg(rjdm_pkg::REG_ACTIVE, 17'd1);
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame('1, '1);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
   endtask

   // random settings for one phase, mostly short taps so history comes back
   task automatic configure_phase();
      logic [16:0] value;
      bit          turn_on;
      turn_on = ($urandom_range(99) < 85);
      case ($urandom_range(9))
         0: value = 17'd0;
         1: value = 17'($urandom_range(16382, 16383));
         2: value = 17'($urandom);
         3: value = 17'($urandom_range(25, 16383));
         default: value = 17'($urandom_range(1, 24));
      endcase
      write_reg(rjdm_pkg::REG_BASE_DELAY, value);
      case ($urandom_range(9))
         0: value = 17'd0;
         1: value = 17'($urandom);
         2: value = 17'($urandom_range(13, 16383));
         default: value = 17'($urandom_range(1, 12));
      endcase
      write_reg(rjdm_pkg::REG_JITTER_RANGE, value);
      case ($urandom_range(9))
         0: value = 17'd0;
         1: value = 17'($urandom_range(FULL_WET + 1, 131071));
         2, 3: value = 17'(FULL_WET);
         default: value = 17'($urandom_range(0, FULL_WET));
      endcase
      write_reg(rjdm_pkg::REG_MIX, value);
      write_reg(rjdm_pkg::REG_ACTIVE, {16'($urandom), turn_on});
   endtask

   // random phases of random frames, one phase without any idling
   task automatic test_random();
      int sent;
      int phase;
      int count;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_FRAMES) begin
         wait_idle();
         configure_phase();
         calm_mode = (phase == 2);
         count     = calm_mode ? CALM_FRAMES : $urandom_range(15, 60);
         repeat (count) send_frame(random_sample(), random_sample());
         sent += count;
         phase++;
      end
      wait_idle();
      calm_mode = 1'b0;
   endtask

   initial begin
      cfg_active = 1'b0;
      cfg_base   = 14'd1;
      cfg_jitter = 14'd1;
      cfg_mix    = 17'd0;
      clear_delay_line();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_left_in  <= '0;
      req_right_in <= '0;
      rsp_ready    <= 1'b0;
      csr_valid    <= 1'b0;
      csr_index    <= rjdm_pkg::REG_ACTIVE;
      csr_wdata    <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_bypass();
      test_wet_path();
      test_deactivate();
      test_random();

      // let any stray result show up
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_frames.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_frames.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("tb_random_jitter_delay_mix_top: PASS");
      end else begin
         $display("tb_random_jitter_delay_mix_top: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
